// File: rtl/msbt_pkg.sv
// msbt_pkg: shared types and constants for the multiset bag table
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps

package msbt_pkg;

   // fixed field widths of the ports
   localparam int VALUE_IN_W = 32;
   localparam int FIELD_W    = 7;

   typedef enum logic [1:0] {
      ACT_INSERT    = 2'd0,
      ACT_ERASE_ONE = 2'd1,
      ACT_ERASE_ALL = 2'd2,
      ACT_COUNT     = 2'd3
   } action_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture a new item
      logic rd_en;      // read the entry store
      logic rd_last;    // read at the last held entry instead of the scan index
      logic wr_en;      // write the entry store
      logic wr_insert;  // write the item value at the fill position
      logic idx_inc;
      logic fill_inc;
      logic fill_dec;
      logic num_inc;
      logic reject;
   } msbt_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      action_type action;
      logic       hit;       // read data equals the item value
      logic       scan_end;  // scan index at or past the fill count
      logic       full;
   } msbt_stat_type;

endpackage

// File: rtl/msbt_ram.sv
// msbt_ram: generic single write port, single read port RAM with registered read
// no dependencies
`timescale 1ns / 1ps

module msbt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/msbt_dp.sv
// msbt_dp: datapath of the bag table: item registers, fill count, scan index,
// match counter and the entry store; uses msbt_pkg and msbt_ram
`timescale 1ns / 1ps

module msbt_dp #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_action,
   input  logic [msbt_pkg::VALUE_IN_W-1:0]   req_value,
   input  msbt_pkg::msbt_cmd_type            cmd,
   output msbt_pkg::msbt_stat_type           stat,
   output logic                              rsp_status,
   output logic [msbt_pkg::FIELD_W-1:0]      rsp_number,
   output logic [msbt_pkg::FIELD_W-1:0]      rsp_size
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   msbt_pkg::action_type   action_ff, action_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       number_ff, number_in;
   logic                   status_ff, status_in;

   logic [VALUE_WIDTH+msbt_pkg::VALUE_IN_W-1:0] value_ext;
   logic [CNT_W+msbt_pkg::FIELD_W-1:0]          number_ext, size_ext;
   logic [ADDR_W-1:0]      wr_addr, rd_addr;
   logic [VALUE_WIDTH-1:0] wr_data, rd_data;

   // value is taken modulo 2^VALUE_WIDTH, zero extended when wider
   assign value_ext = {{VALUE_WIDTH{1'b0}}, req_value};

   always_comb begin
      action_in = action_ff;
      value_in  = value_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      number_in = number_ff;
      status_in = status_ff;
      if (cmd.load) begin
         action_in = msbt_pkg::action_type'(req_action);
         value_in  = value_ext[VALUE_WIDTH-1:0];
         idx_in    = '0;
         number_in = '0;
         status_in = 1'b0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.fill_inc) begin
         fill_in = fill_ff + 1'b1;
      end else if (cmd.fill_dec) begin
         fill_in = fill_ff - 1'b1;
      end
      if (cmd.num_inc) begin
         number_in = number_ff + 1'b1;
      end
      if (cmd.reject) begin
         status_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
      action_ff <= action_in;
      value_ff  <= value_in;
      idx_ff    <= idx_in;
      number_ff <= number_in;
      status_ff <= status_in;
   end

   // after a removal the fill count already points at the last held entry
   assign rd_addr = cmd.rd_last ? fill_ff[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
   assign wr_addr = cmd.wr_insert ? fill_ff[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
   assign wr_data = cmd.wr_insert ? value_ff : rd_data;

   msbt_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.action   = action_ff;
   assign stat.hit      = (rd_data == value_ff);
   assign stat.scan_end = (idx_ff >= fill_ff);
   assign stat.full     = (fill_ff == CNT_W'(CAPACITY));

   assign number_ext = {{msbt_pkg::FIELD_W{1'b0}}, number_ff};
   assign size_ext   = {{msbt_pkg::FIELD_W{1'b0}}, fill_ff};
   assign rsp_status = status_ff;
   assign rsp_number = number_ext[msbt_pkg::FIELD_W-1:0];
   assign rsp_size   = size_ext[msbt_pkg::FIELD_W-1:0];

   a_reject_only_full: assert property (@(posedge clock) disable iff (reset)
      cmd.reject |-> stat.full)
      else $error("insert rejected while store not full");

   a_fill_moves_on_cmd: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && fill_ff != $past(fill_ff)) |->
         ($past(cmd.fill_inc) || $past(cmd.fill_dec)))
      else $error("fill count changed without a command");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_inc |-> !stat.full)
      else $error("fill count grows past capacity");

   a_scan_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && !cmd.wr_insert) |-> !stat.scan_end)
      else $error("move target outside held entries");

endmodule

// File: rtl/msbt_ctrl.sv
// msbt_ctrl: controller state machine of the bag table; sequences the scan,
// removal and insert steps; uses msbt_pkg
`timescale 1ns / 1ps

module msbt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  msbt_pkg::msbt_stat_type stat,
   output msbt_pkg::msbt_cmd_type  cmd,
   output logic                    busy,
   output logic                    rsp_strobe
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_LAST_RD,
      S_LAST_CMP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, strobe_ff;
   logic      done;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      done     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy_ff) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.action == msbt_pkg::ACT_INSERT) begin
               if (stat.full) begin
                  cmd.reject = 1'b1;
               end else begin
                  cmd.wr_en     = 1'b1;
                  cmd.wr_insert = 1'b1;
                  cmd.fill_inc  = 1'b1;
               end
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (stat.scan_end) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (stat.hit && stat.action != msbt_pkg::ACT_COUNT) begin
               // drop this entry, then fetch the last one to fill the hole
               cmd.fill_dec = 1'b1;
               cmd.num_inc  = 1'b1;
               state_in     = S_LAST_RD;
            end else begin
               cmd.num_inc = stat.hit;
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_LAST_RD: begin
            // removed entry was the last one held
            if (stat.scan_end) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_last = 1'b1;
               state_in    = S_LAST_CMP;
            end
         end
         S_LAST_CMP: begin
            if (stat.action == msbt_pkg::ACT_ERASE_ALL && stat.hit) begin
               // moved entry matches too: drop it without writing
               cmd.fill_dec = 1'b1;
               cmd.num_inc  = 1'b1;
               state_in     = S_LAST_RD;
            end else if (stat.action == msbt_pkg::ACT_ERASE_ALL) begin
               cmd.wr_en   = 1'b1;
               cmd.idx_inc = 1'b1;
               state_in    = S_SCAN_RD;
            end else begin
               cmd.wr_en = 1'b1;
               done      = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != S_IDLE);
         strobe_ff <= done;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> (busy_ff && state_ff == S_DECIDE))
      else $error("accepted item did not start work");

   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (!busy_ff && state_ff == S_IDLE))
      else $error("result strobe while still working");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("two results back to back");

endmodule

// File: rtl/multiset_bag_table.sv
// multiset_bag_table: unordered multiset held in a fixed entry store with a fill count
// top level; instantiates msbt_ctrl and msbt_dp, uses msbt_pkg
//
//   channel   ports                                   transfer
//   request   start, busy, req_action, req_value      start high while busy low
//   result    rsp_strobe, rsp_status, rsp_number,     one cycle while rsp_strobe high
//             rsp_size
//
// an insert is decided in S_DECIDE, and its result strobe is registered from there
// erase and count scan the held entries one at a time through the single
// read port of the entry store, each entry read in S_SCAN_RD and compared in S_SCAN_CMP
// busy is high from the cycle after accept until the result strobe; the next item
// may start in the strobe cycle; results cannot be held off by the receiver
// synchronous reset empties the store at once (fill count only, no clearing pass)
`timescale 1ns / 1ps

module multiset_bag_table #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_action,
   input  logic [msbt_pkg::VALUE_IN_W-1:0] req_value,
   output logic                            rsp_strobe,
   output logic                            rsp_status,
   output logic [msbt_pkg::FIELD_W-1:0]    rsp_number,
   output logic [msbt_pkg::FIELD_W-1:0]    rsp_size
);

   msbt_pkg::msbt_cmd_type  cmd;
   msbt_pkg::msbt_stat_type stat;

   msbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   msbt_dp #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_action (req_action),
      .req_value  (req_value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_status (rsp_status),
      .rsp_number (rsp_number),
      .rsp_size   (rsp_size)
   );

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking bench for multiset_bag_table, with a queue-fed driver and a monitor
// needs rtl/msbt_pkg.sv and all other rtl/ files; a local bag model predicts each result
`timescale 1ns / 1ps

module tb_top;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int IDLE_LIMIT  = 1500;
   localparam int TAIL_CYCLES = 2 * CAPACITY + 20;
   localparam int RANDOM_OPS  = 850;

   typedef enum int {
      MODE_FILL  = 0,
      MODE_DRAIN = 1,
      MODE_MIXED = 2,
      MODE_NOISE = 3
   } phase_mode_type;

   typedef struct {
      msbt_pkg::action_type act;
      logic [31:0]          value;
      int                   gap;
      bit                   drain;
   } bag_op_type;

   typedef struct {
      logic                        status;
      logic [msbt_pkg::FIELD_W-1:0] number;
      logic [msbt_pkg::FIELD_W-1:0] size;
   } bag_result_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            start      = 1'b0;
   logic [1:0]                      req_action = msbt_pkg::ACT_INSERT;
   logic [msbt_pkg::VALUE_IN_W-1:0] req_value  = '0;
   logic                            busy;
   logic                            rsp_strobe;
   logic                            rsp_status;
   logic [msbt_pkg::FIELD_W-1:0]    rsp_number;
   logic [msbt_pkg::FIELD_W-1:0]    rsp_size;

   bag_op_type     bag_ops[$];
   bag_result_type expected_answers[$];

   // local copy of the bag
   logic [VALUE_WIDTH-1:0] bag_entries[CAPACITY];
   int                     bag_fill = 0;

   int             error_count  = 0;
   int             items_sent   = 0;
   int             results_seen = 0;
   int             idle_cycles  = 0;
   bag_op_type     cur_op;
   bit             have_op      = 0;
   int             gap_left     = 0;
   bit             accepted;
   bit             start_n;
   bag_result_type got;
   bag_result_type want;

   logic [31:0] value_pool[8];
   int          pool_n;

   multiset_bag_table #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_value  (req_value),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .rsp_number (rsp_number),
      .rsp_size   (rsp_size)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic bag_result_type predict_bag(msbt_pkg::action_type act,
                                                  logic [31:0] raw);
      bag_result_type         res;
      logic [VALUE_WIDTH-1:0] v;
      int                     i;
      int                     hits;
      bit                     found;
      v = raw[VALUE_WIDTH-1:0];
      res.status = 1'b0;
      hits = 0;
      case (act)
         msbt_pkg::ACT_INSERT: begin
            if (bag_fill >= CAPACITY) begin
               res.status = 1'b1;
            end else begin
               bag_entries[bag_fill] = v;
               bag_fill++;
            end
         end
         msbt_pkg::ACT_ERASE_ONE: begin
            found = 0;
            i = 0;
            while (!found && i < bag_fill) begin
               if (bag_entries[i] == v) begin
                  // last entry moves into the freed place
                  bag_fill--;
                  bag_entries[i] = bag_entries[bag_fill];
                  found = 1;
                  hits = 1;
               end else begin
                  i++;
               end
            end
         end
         msbt_pkg::ACT_ERASE_ALL: begin
            i = 0;
            while (i < bag_fill) begin
               if (bag_entries[i] == v) begin
                  bag_fill--;
                  bag_entries[i] = bag_entries[bag_fill];
                  hits++;
               end else begin
                  i++;
               end
            end
         end
         default: begin
            for (i = 0; i < bag_fill; i++) begin
               if (bag_entries[i] == v) hits++;
            end
         end
      endcase
      res.number = msbt_pkg::FIELD_W'(hits);
      res.size   = msbt_pkg::FIELD_W'(bag_fill);
      return res;
   endfunction

   task automatic add_op(msbt_pkg::action_type act, logic [31:0] value, int gap, bit drain);
      bag_op_type op;
      op.act   = act;
      op.value = value;
      op.gap   = gap;
      op.drain = drain;
      bag_ops.push_back(op);
   endtask

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return value_pool[$urandom_range(0, pool_n - 1)];
      if (r < 90) return 32'h0000_0000;
      if (r < 95) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   task automatic fresh_pool();
      int i;
      int r;
      pool_n = $urandom_range(1, 8);
      for (i = 0; i < pool_n; i++) begin
         r = $urandom_range(0, 9);
         if (r == 0) value_pool[i] = 32'h0000_0000;
         else if (r == 1) value_pool[i] = 32'hFFFF_FFFF;
         else if (r == 2) value_pool[i] = 32'h1 << $urandom_range(0, 31);
         else value_pool[i] = $urandom;
      end
   endtask

   task automatic build_random_ops();
      int                   total;
      int                   len;
      int                   k;
      int                   r;
      bit                   no_gaps;
      phase_mode_type       mode;
      msbt_pkg::action_type act;
      logic [31:0]          one_value;
      total = 0;
      // opening sequence: fill with one value past capacity, then count and sweep it
      one_value = $urandom;
      for (k = 0; k < CAPACITY + 3; k++) begin
         add_op(msbt_pkg::ACT_INSERT, one_value, (k == 0) ? 0 : $urandom_range(0, 3),
                k == 0);
      end
      add_op(msbt_pkg::ACT_COUNT, one_value, $urandom_range(0, 3), 0);
      add_op(msbt_pkg::ACT_ERASE_ALL, one_value, $urandom_range(0, 3), 0);
      total = CAPACITY + 5;
      while (total < RANDOM_OPS) begin
         mode    = phase_mode_type'($urandom_range(0, 3));
         len     = $urandom_range(30, 120);
         no_gaps = ($urandom_range(0, 3) == 0);
         fresh_pool();
         for (k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            case (mode)
               MODE_FILL: begin
                  if (r < 85) act = msbt_pkg::ACT_INSERT;
                  else act = msbt_pkg::action_type'($urandom_range(1, 3));
               end
               MODE_DRAIN: begin
                  if (r < 15) act = msbt_pkg::ACT_INSERT;
                  else if (r < 50) act = msbt_pkg::ACT_ERASE_ONE;
                  else if (r < 75) act = msbt_pkg::ACT_ERASE_ALL;
                  else act = msbt_pkg::ACT_COUNT;
               end
               default:    act = msbt_pkg::action_type'($urandom_range(0, 3));
            endcase
            add_op(act, (mode == MODE_NOISE) ? $urandom : pick_value(),
                   no_gaps ? 0 : $urandom_range(0, 3),
                   (k == 0) && ($urandom_range(0, 3) == 0));
         end
         total += len;
      end
   endtask

   // driver: one item at a time from bag_ops, start held until busy is low
   always @(posedge clock) begin
      if (reset) begin
         start   <= 1'b0;
         have_op  = 0;
         gap_left = 0;
      end else begin
         accepted = start && !busy;
         if (accepted) begin
            expected_answers.push_back(predict_bag(cur_op.act, cur_op.value));
            items_sent++;
            have_op = 0;
         end
         if (!start || accepted) begin
            if (!have_op && bag_ops.size() > 0) begin
               cur_op   = bag_ops.pop_front();
               have_op  = 1;
               gap_left = cur_op.gap;
            end else if (have_op && !busy && gap_left > 0) begin
               // idle cycles only count while the block could take an item
               gap_left--;
            end
            start_n = 1'b0;
            if (have_op && gap_left == 0) begin
               if (!cur_op.drain || items_sent == results_seen) begin
                  start_n = 1'b1;
                  req_action <= cur_op.act;
                  req_value  <= cur_op.value;
               end
            end
            start <= start_n;
         end
      end
   end

   // monitor: every strobe is a result that must match the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got.status = rsp_status;
         got.number = rsp_number;
         got.size   = rsp_size;
         if (expected_answers.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = expected_answers.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0b, expected %0b", got.status, want.status));
            if (got.number !== want.number)
               report_mismatch($sformatf("number %0d, expected %0d", got.number, want.number));
            if (got.size !== want.size)
               report_mismatch($sformatf("size %0d, expected %0d", got.size, want.size));
         end
         results_seen <= results_seen + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item or result for %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // directed: empty store, extremes, duplicates, misses, moves of the last entry
      add_op(msbt_pkg::ACT_COUNT,     32'h0000_0000, 0, 0);
      add_op(msbt_pkg::ACT_ERASE_ONE, 32'h0000_0000, 1, 0);
      add_op(msbt_pkg::ACT_ERASE_ALL, 32'hFFFF_FFFF, 0, 0);
      add_op(msbt_pkg::ACT_INSERT,    32'h0000_0000, 2, 0);
      add_op(msbt_pkg::ACT_INSERT,    32'hFFFF_FFFF, 0, 0);
      add_op(msbt_pkg::ACT_INSERT,    32'h0000_0000, 3, 0);
      add_op(msbt_pkg::ACT_INSERT,    32'h8000_0001, 0, 0);
      add_op(msbt_pkg::ACT_INSERT,    32'h0000_0000, 1, 0);
      add_op(msbt_pkg::ACT_COUNT,     32'h0000_0000, 0, 0);
      add_op(msbt_pkg::ACT_COUNT,     32'hFFFF_FFFF, 0, 0);
      add_op(msbt_pkg::ACT_ERASE_ONE, 32'h1234_5678, 2, 0);
      add_op(msbt_pkg::ACT_ERASE_ONE, 32'h0000_0000, 0, 0);
      add_op(msbt_pkg::ACT_ERASE_ALL, 32'h0000_0000, 0, 0);
      add_op(msbt_pkg::ACT_COUNT,     32'h0000_0000, 3, 0);
      add_op(msbt_pkg::ACT_ERASE_ALL, 32'h5555_5555, 0, 0);
      add_op(msbt_pkg::ACT_INSERT,    32'h7FFF_FFFF, 0, 0);
      add_op(msbt_pkg::ACT_INSERT,    32'h7FFF_FFFF, 1, 0);
      add_op(msbt_pkg::ACT_ERASE_ONE, 32'hFFFF_FFFF, 0, 0);
      add_op(msbt_pkg::ACT_COUNT,     32'h7FFF_FFFF, 0, 0);
      add_op(msbt_pkg::ACT_ERASE_ALL, 32'h7FFF_FFFF, 2, 0);
      add_op(msbt_pkg::ACT_ERASE_ONE, 32'h8000_0001, 0, 0);
      add_op(msbt_pkg::ACT_COUNT,     32'h8000_0001, 0, 0);
      build_random_ops();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (bag_ops.size() > 0 || have_op || start || items_sent != results_seen)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_answers.size() > 0)
         report_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
